### rtl/mmcd_pkg.sv
`timescale 1ns / 1ps
package mmcd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SPAN_W   = 24;
  localparam int ACC_W    = 25;
  localparam int IDX_W    = 16;
  localparam int JOIN_W   = 20;

  localparam logic [ACC_W-1:0]  ONE_SAMPLE = 25'd256;
  localparam logic [SPAN_W-1:0] MIN_SPAN   = 24'd512;
  localparam logic [SPAN_W-1:0] SPAN_RESET = 24'd512;

  typedef struct packed {
    logic                       final_column;
    logic [IDX_W-1:0]           column_index;
    logic signed [SAMPLE_W-1:0] column_max;
    logic signed [SAMPLE_W-1:0] column_min;
  } column_t;

endpackage

### rtl/min_max_column_decimator_unit.sv
`timescale 1ns / 1ps
// Min/max column decimator.
// Input stream: in_tdata carries one signed 16-bit sample per word, in_tlast
// marks the final sample of the visible range and closes the frame.
// Output stream: one word per display column; out_tdata holds column_min,
// column_max and column_index, out_tlast flags the column closed by in_tlast.
// cfg_we/cfg_wdata load samples_per_column (unsigned, 8 fraction bits,
// values under 2.0 act as 2.0); write it only while the stream is idle.
// Throughput: one sample per clock while no closing sample waits for the
// output register to free up. An accepted sample sits in the input register
// and updates the column state when it fires; a column it closes loads the
// output register on that same clock, raising out_tvalid. The column state
// loop (accumulator, min/max, span join) is combinational and sets this rate.
// Reset clears all frame state and loads 2.0 samples per column.
// When out_tready is low a finished column holds in the output register;
// samples that do not close a column are still taken, and the input stalls
// only once a second column is ready.
module min_max_column_decimator_unit
  import mmcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [15:0] sample
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,  // [15:0] column_min, [31:16] column_max,
                                        // [47:32] column_index
  output logic              out_tlast,
  input  logic              cfg_we,
  input  logic [SPAN_W-1:0] cfg_wdata
);

  logic                       in_valid_r;
  logic signed [SAMPLE_W-1:0] in_sample_r;
  logic                       in_last_r;
  logic [SPAN_W-1:0]          span_r;
  logic                       out_valid_r;
  column_t                    out_col_r, col;
  logic                       emit, fire, out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign fire      = in_valid_r && (out_free || !emit);
  assign in_tready = !in_valid_r || fire;

  mmcd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .sample   (in_sample_r),
    .last     (in_last_r),
    .span_cfg (span_r),
    .emit     (emit),
    .column   (col)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= SPAN_RESET;
    end else if (cfg_we) begin
      span_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_sample_r <= $signed(in_tdata);
      in_last_r   <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_col_r <= col;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_col_r.column_index, out_col_r.column_max, out_col_r.column_min};
  assign out_tlast  = out_col_r.final_column;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_col_r))
    else $error("pending column overwritten");
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !fire |=> in_valid_r && $stable(in_sample_r) && $stable(in_last_r))
    else $error("input stage lost a word");
  a_fire_room: assert property (@(posedge clk) disable iff (!rst_n)
    fire && emit |-> out_free) else $error("column issued with no output room");
`endif

endmodule

### rtl/mmcd_join.sv
`timescale 1ns / 1ps
module mmcd_join
  import mmcd_pkg::*;
(
  input  logic signed [SAMPLE_W-1:0] prev_min,
  input  logic signed [SAMPLE_W-1:0] prev_max,
  input  logic signed [SAMPLE_W-1:0] run_min,
  input  logic signed [SAMPLE_W-1:0] run_max,
  output logic signed [SAMPLE_W-1:0] join_min,
  output logic signed [SAMPLE_W-1:0] join_max
);

  logic signed [SAMPLE_W:0] p_diff, c_diff, p_adj, c_adj, p_half, c_half;
  logic signed [JOIN_W-1:0] p_ctr, c_ctr, dir, mag, lim;

  assign p_diff = (SAMPLE_W+1)'(prev_max) - (SAMPLE_W+1)'(prev_min);
  assign c_diff = (SAMPLE_W+1)'(run_max) - (SAMPLE_W+1)'(run_min);

  // truncate toward zero
  assign p_adj  = p_diff + $signed({{SAMPLE_W{1'b0}}, p_diff[SAMPLE_W]});
  assign c_adj  = c_diff + $signed({{SAMPLE_W{1'b0}}, c_diff[SAMPLE_W]});
  assign p_half = p_adj >>> 1;
  assign c_half = c_adj >>> 1;

  assign p_ctr = JOIN_W'(prev_min) + JOIN_W'(p_half);
  assign c_ctr = JOIN_W'(run_min) + JOIN_W'(c_half);
  assign dir   = p_ctr - c_ctr;
  assign mag   = (dir < 0) ? -dir : dir;
  assign lim   = JOIN_W'(p_half) + JOIN_W'(c_half);

  always_comb begin
    join_min = run_min;
    join_max = run_max;
    if (mag > lim) begin
      if (dir > 0) begin
        join_max = prev_min;
      end else begin
        join_min = prev_max;
      end
    end
  end

endmodule

### rtl/mmcd_core.sv
`timescale 1ns / 1ps
module mmcd_core
  import mmcd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last,
  input  logic [SPAN_W-1:0]          span_cfg,
  output logic                       emit,
  output column_t                    column
);

  logic [ACC_W-1:0]          acc_r, acc_nxt, acc_base, acc_add;
  logic signed [SAMPLE_W-1:0] rmin_r, rmin_nxt, rmax_r, rmax_nxt;
  logic signed [SAMPLE_W-1:0] pmin_r, pmin_nxt, pmax_r, pmax_nxt;
  logic signed [SAMPLE_W-1:0] pmin_use, pmax_use, jmin, jmax;
  logic                      open_r, open_nxt, started_r, started_nxt;
  logic [IDX_W-1:0]          cnt_r, cnt_nxt, cnt_use;
  logic [SPAN_W-1:0]         span;
  logic                      reached;

  assign span     = (span_cfg < MIN_SPAN) ? MIN_SPAN : span_cfg;
  assign acc_base = started_r ? acc_r : '0;
  assign cnt_use  = started_r ? cnt_r : '0;
  assign pmin_use = started_r ? pmin_r : sample;
  assign pmax_use = started_r ? pmax_r : sample;
  assign acc_add  = acc_base + ONE_SAMPLE;
  assign reached  = acc_add >= ACC_W'(span);

  always_comb begin
    if (!(open_r && started_r)) begin
      rmin_nxt = sample;
      rmax_nxt = sample;
    end else if (sample > rmax_r) begin
      rmin_nxt = rmin_r;
      rmax_nxt = sample;
    end else if (sample < rmin_r) begin
      rmin_nxt = sample;
      rmax_nxt = rmax_r;
    end else begin
      rmin_nxt = rmin_r;
      rmax_nxt = rmax_r;
    end
  end

  mmcd_join u_join (
    .prev_min (pmin_use),
    .prev_max (pmax_use),
    .run_min  (rmin_nxt),
    .run_max  (rmax_nxt),
    .join_min (jmin),
    .join_max (jmax)
  );

  assign emit = reached || last;

  assign column = {last, cnt_use, jmax, jmin};

  always_comb begin
    acc_nxt     = reached ? (acc_add - ACC_W'(span)) : acc_add;
    pmin_nxt    = emit ? jmin : pmin_use;
    pmax_nxt    = emit ? jmax : pmax_use;
    cnt_nxt     = emit ? (cnt_use + 1'b1) : cnt_use;
    open_nxt    = !emit;
    started_nxt = 1'b1;
    if (last) begin
      acc_nxt     = '0;
      cnt_nxt     = '0;
      started_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      rmin_r    <= '0;
      rmax_r    <= '0;
      pmin_r    <= '0;
      pmax_r    <= '0;
      open_r    <= 1'b0;
      started_r <= 1'b0;
      cnt_r     <= '0;
    end else if (fire) begin
      acc_r     <= acc_nxt;
      rmin_r    <= rmin_nxt;
      rmax_r    <= rmax_nxt;
      pmin_r    <= pmin_nxt;
      pmax_r    <= pmax_nxt;
      open_r    <= open_nxt;
      started_r <= started_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_open_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> started_r) else $error("column open outside a frame");
  a_span_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (rmin_r <= rmax_r)) else $error("running min above running max");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && last |=> !started_r && (cnt_r == '0) && !open_r)
    else $error("frame state not cleared after last word");
  a_hold_open: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !emit |=> open_r) else $error("column closed without a result");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mmcd_pkg::*;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_CAP    = 40;
  localparam int PHASES        = 11;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    bit                         lst;
    bit                         typed;
    bit                         hit;
    column_t                    want;
  } plan_row_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata   = '0;
  logic              in_tlast   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [47:0]       out_tdata;
  logic              out_tlast;
  logic              cfg_we     = 1'b0;
  logic [SPAN_W-1:0] cfg_wdata  = '0;

  logic [SPAN_W-1:0]          span_reg  = SPAN_RESET;
  logic [ACC_W-1:0]           col_phase = '0;
  logic signed [SAMPLE_W-1:0] lo_run    = '0;
  logic signed [SAMPLE_W-1:0] hi_run    = '0;
  logic signed [SAMPLE_W-1:0] lo_prev   = '0;
  logic signed [SAMPLE_W-1:0] hi_prev   = '0;
  bit                         in_column = 1'b0;
  bit                         in_frame  = 1'b0;
  logic [IDX_W-1:0]           col_num   = '0;

  column_t                    pending_columns[$];
  column_t                    seen_col;
  column_t                    due_col;
  logic signed [SAMPLE_W-1:0] last_sample = '0;

  int errors       = 0;
  int samples_sent = 0;
  int frames_sent  = 0;
  int columns_seen = 0;
  int spans_used   = 0;
  int quiet        = 0;
  int burst_left   = 0;
  int stall_mode   = 0;
  int stall_left   = 0;
  int pat_cnt      = 0;

  min_max_column_decimator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit fold_sample(input logic signed [SAMPLE_W-1:0] s, input bit lst,
                                     output column_t col);
    logic [SPAN_W-1:0] span;
    bit reached;
    int pmin, pmax, cmin, cmax, ph, ch, dir, mag;
    span = (span_reg < MIN_SPAN) ? MIN_SPAN : span_reg;
    col = '0;
    if (!in_frame) begin
      lo_prev   = s;
      hi_prev   = s;
      in_frame  = 1'b1;
      col_phase = '0;
      col_num   = '0;
      in_column = 1'b0;
    end
    if (!in_column) begin
      lo_run    = s;
      hi_run    = s;
      in_column = 1'b1;
    end else if (s > hi_run) begin
      hi_run = s;
    end else if (s < lo_run) begin
      lo_run = s;
    end
    col_phase = col_phase + ONE_SAMPLE;
    reached = col_phase >= {1'b0, span};
    if (!reached && !lst) return 1'b0;
    pmin = lo_prev;
    pmax = hi_prev;
    cmin = lo_run;
    cmax = hi_run;
    ph = (pmax - pmin) / 2;
    ch = (cmax - cmin) / 2;
    dir = (pmin + ph) - (cmin + ch);
    mag = (dir < 0) ? -dir : dir;
    if (mag > ph + ch) begin
      if (dir > 0) cmax = pmin;
      else cmin = pmax;
    end
    col.column_min   = cmin[15:0];
    col.column_max   = cmax[15:0];
    col.column_index = col_num;
    col.final_column = lst;
    if (reached) col_phase = col_phase - span;
    lo_prev   = cmin[15:0];
    hi_prev   = cmax[15:0];
    col_num   = col_num + 1'b1;
    in_column = 1'b0;
    if (lst) begin
      in_frame  = 1'b0;
      col_phase = '0;
      col_num   = '0;
    end
    return 1'b1;
  endfunction

  function automatic plan_row_t plan_row(input int smp, input bit lst, input bit typed,
                                         input bit hit, input int mn, input int mx,
                                         input int ix, input bit fn);
    plan_row_t r;
    r.smp = smp[15:0];
    r.lst = lst;
    r.typed = typed;
    r.hit = hit;
    r.want.column_min = mn[15:0];
    r.want.column_max = mx[15:0];
    r.want.column_index = ix[15:0];
    r.want.final_column = fn;
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(
      input logic signed [SAMPLE_W-1:0] near);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = near + int'($urandom_range(0, 600)) - 300;
      5, 6: v = int'($urandom_range(0, 65535)) - 32768;
      7: v = $urandom_range(0, 1) ? 32767 : -32768;
      8: v = int'($urandom_range(0, 64)) - 32;
      default: v = near;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic report(input string what, input int got, input int want);
    errors++;
    if (errors <= REPORT_CAP)
      $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit lst,
                             input bit typed, input bit hit, input column_t want);
    column_t col;
    bit closes;
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    closes = fold_sample(s, lst, col);
    if (typed) begin
      if (hit) pending_columns.push_back(want);
    end else if (closes) begin
      pending_columns.push_back(col);
    end
    samples_sent++;
    if (lst) frames_sent++;
    last_sample = s;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_columns.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_span(input logic [SPAN_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    span_reg = v;
    spans_used++;
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    pat_cnt++;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (pat_cnt % 7) < 3;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen_col.column_min   = out_tdata[15:0];
        seen_col.column_max   = out_tdata[31:16];
        seen_col.column_index = out_tdata[47:32];
        seen_col.final_column = out_tlast;
        columns_seen++;
        if (pending_columns.size() == 0) begin
          report("unexpected column word", seen_col.column_index, -1);
        end else begin
          due_col = pending_columns.pop_front();
          if (seen_col.column_min !== due_col.column_min)
            report("column_min", seen_col.column_min, due_col.column_min);
          if (seen_col.column_max !== due_col.column_max)
            report("column_max", seen_col.column_max, due_col.column_max);
          if (seen_col.column_index !== due_col.column_index)
            report("column_index", seen_col.column_index, due_col.column_index);
          if (seen_col.final_column !== due_col.final_column)
            report("final_column", seen_col.final_column, due_col.final_column);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("stalled for %0d cycles with %0d column words outstanding",
                   quiet, pending_columns.size());
          $display("tb_top: errors");
          $finish;
        end
      end
    end
  end

  initial begin
    plan_row_t         steps[$];
    logic [SPAN_W-1:0] span_plan [PHASES];
    int                item_plan [PHASES];
    int                odds;
    steps.push_back(plan_row(32767, 0, 1, 0, 0, 0, 0, 0));
    steps.push_back(plan_row(-32768, 0, 1, 1, -32768, 32767, 0, 0));
    steps.push_back(plan_row(0, 1, 1, 1, 0, 0, 1, 1));
    steps.push_back(plan_row(-1, 1, 1, 1, -1, -1, 0, 1));
    steps.push_back(plan_row(100, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(plan_row(100, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(plan_row(1000, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(plan_row(1000, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(plan_row(-500, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(plan_row(-500, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(plan_row(-500, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(plan_row(-400, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(plan_row(-32768, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(plan_row(32767, 1, 0, 0, 0, 0, 0, 0));
    steps.push_back(plan_row(32767, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(plan_row(32767, 1, 0, 0, 0, 0, 0, 0));
    steps.push_back(plan_row(5, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(plan_row(-5, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(plan_row(20000, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(plan_row(-20000, 1, 0, 0, 0, 0, 0, 0));
    steps.push_back(plan_row(1, 1, 1, 1, 1, 1, 0, 1));
    span_plan = '{24'd0, 24'd511, 24'd513, 24'd640, 24'd768, 24'd1000, 24'd2560,
                  24'hFFFFFF, 24'($urandom_range(512, 1536)),
                  24'($urandom_range(512, 65535)), SPAN_RESET};
    item_plan = '{80, 80, 100, 100, 100, 80, 120, 120, 100, 60, 100};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (steps[i])
      send_sample(steps[i].smp, steps[i].lst, steps[i].typed, steps[i].hit, steps[i].want);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_span(span_plan[p]);
      odds = (span_plan[p] > 24'h4000) ? 8 : 40;
      repeat (item_plan[p])
        send_sample(pick_sample(last_sample), $urandom_range(1, odds) == 1, 1'b0, 1'b0, '0);
    end
    settle();

    $display("%0d samples in %0d closed frames across %0d span settings",
             samples_sent, frames_sent, spans_used);
    $display("%0d column words checked, %0d mismatches", columns_seen, errors);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
